// ===== hw/rtl/h2r_pkg.sv =====
// ----------------------------------------------------------------------------
// h2r_pkg
// Shared types for the HSV to RGB converter: pipeline advance strobes and
// hue sector codes.
// ----------------------------------------------------------------------------
`default_nettype none

package h2r_pkg;

  // Advance strobes for the two blend stages
  typedef struct packed {
    logic mix_en;
    logic out_en;
  } h2r_adv_t;

  // Hue sectors, named after the full and ramping channels
  typedef enum logic [2:0] {
    SEC_R_UPG = 3'd0,  // red full, green rising
    SEC_G_DNR = 3'd1,  // green full, red falling
    SEC_G_UPB = 3'd2,  // green full, blue rising
    SEC_B_DNG = 3'd3,  // blue full, green falling
    SEC_B_UPR = 3'd4,  // blue full, red rising
    SEC_R_DNB = 3'd5   // red full, blue falling
  } h2r_sector_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Fixed-point HSV to RGB colour conversion, four-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one pixel per transaction:
//   hue, saturation and brightness, unsigned with FRAC_BITS fraction bits,
//   1.0 = 2^FRAC_BITS. Values above 1.0 saturate to 1.0.
//   Output channel (out_valid / out_stall) returns red, green, blue in the
//   same format, one transaction per input transaction, in order.
//   Stages: clamp, sector, saturation blend, brightness multiply.
//   Throughput: one pixel per clock while out_stall is low;
//   each stage holds one pixel.
//   Stalls: a stage moves when it is empty or the stage after it moves, so
//   bubbles close up and in_stall only rises once all four stages are
//   full and out_stall is high. A stalled result is held unchanged.
//   Reset: rst_n (synchronous, active low) clears the stage valid bits;
//   data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [FRAC_BITS:0] in_hue,
  input  wire logic [FRAC_BITS:0] in_saturation,
  input  wire logic [FRAC_BITS:0] in_brightness,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [FRAC_BITS:0] out_red,
  output logic      [FRAC_BITS:0] out_green,
  output logic      [FRAC_BITS:0] out_blue
);
  import h2r_pkg::*;

  localparam int W   = FRAC_BITS + 1;
  localparam int H6W = FRAC_BITS + 4;   // holds 6 * hue

  localparam logic [W-1:0]   ONE   = W'(1) << FRAC_BITS;
  localparam logic [H6W-1:0] ONE_1 = H6W'(1) << FRAC_BITS;
  localparam logic [H6W-1:0] ONE_2 = H6W'(2) << FRAC_BITS;
  localparam logic [H6W-1:0] ONE_3 = H6W'(3) << FRAC_BITS;
  localparam logic [H6W-1:0] ONE_4 = H6W'(4) << FRAC_BITS;
  localparam logic [H6W-1:0] ONE_5 = H6W'(5) << FRAC_BITS;
  localparam logic [H6W-1:0] ONE_6 = H6W'(6) << FRAC_BITS;

  // Stage valid bits
  logic vld1_r, vld2_r, vld3_r, vld4_r;
  logic en1, en2, en3, en4;

  // Stage 1: clamped inputs
  logic [W-1:0] hue1_r, sat1_r, val1_r;
  // Stage 2: base channels plus saturation terms
  logic [W-1:0] cred2_r, cgrn2_r, cblu2_r;
  logic [W-1:0] sat2_r, oms2_r, val2_r;
  logic [W-1:0] cred_nxt, cgrn_nxt, cblu_nxt;
  // Stage 3: brightness follows the blend
  logic [W-1:0] val3_r;

  logic [H6W-1:0] hue6;
  h2r_sector_t    sector;
  h2r_adv_t       adv;

  function automatic logic [W-1:0] clamp_unit(input logic [W-1:0] x);
    clamp_unit = (x > ONE) ? ONE : x;
  endfunction

  // Stall chain: each stage advances if empty or its successor advances
  always_comb begin
    en4 = !vld4_r || !out_stall;
    en3 = !vld3_r || en4;
    en2 = !vld2_r || en3;
    en1 = !vld1_r || en2;
    adv.mix_en = en3;
    adv.out_en = en4;
  end

  assign in_stall  = !en1;
  assign out_valid = vld4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      if (en1) vld1_r <= in_valid;
      if (en2) vld2_r <= vld1_r;
      if (en3) vld3_r <= vld2_r;
      if (en4) vld4_r <= vld3_r;
    end
  end

  // Sector select on 6*hue; the ramp is exact in the same format
  always_comb begin
    hue6 = (H6W'(hue1_r) << 2) + (H6W'(hue1_r) << 1);
    if (hue6 <= ONE_1)      sector = SEC_R_UPG;
    else if (hue6 <= ONE_2) sector = SEC_G_DNR;
    else if (hue6 <= ONE_3) sector = SEC_G_UPB;
    else if (hue6 <= ONE_4) sector = SEC_B_DNG;
    else if (hue6 <= ONE_5) sector = SEC_B_UPR;
    else                    sector = SEC_R_DNB;

    cred_nxt = '0;
    cgrn_nxt = '0;
    cblu_nxt = '0;
    case (sector)
      SEC_R_UPG: begin
        cred_nxt = ONE;
        cgrn_nxt = hue6[W-1:0];
      end
      SEC_G_DNR: begin
        cgrn_nxt = ONE;
        cred_nxt = W'(ONE_2 - hue6);
      end
      SEC_G_UPB: begin
        cgrn_nxt = ONE;
        cblu_nxt = W'(hue6 - ONE_2);
      end
      SEC_B_DNG: begin
        cblu_nxt = ONE;
        cgrn_nxt = W'(ONE_4 - hue6);
      end
      SEC_B_UPR: begin
        cblu_nxt = ONE;
        cred_nxt = W'(hue6 - ONE_4);
      end
      SEC_R_DNB: begin
        cred_nxt = ONE;
        cblu_nxt = W'(ONE_6 - hue6);
      end
      default: begin
        cred_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      hue1_r <= clamp_unit(in_hue);
      sat1_r <= clamp_unit(in_saturation);
      val1_r <= clamp_unit(in_brightness);
    end
    if (en2) begin
      cred2_r <= cred_nxt;
      cgrn2_r <= cgrn_nxt;
      cblu2_r <= cblu_nxt;
      sat2_r  <= sat1_r;
      oms2_r  <= ONE - sat1_r;
      val2_r  <= val1_r;
    end
    if (en3) begin
      val3_r <= val2_r;
    end
  end

  // Per-channel blend: stage 3 saturation mix, stage 4 brightness product
  h2r_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_red (
    .clk(clk), .adv(adv), .chan(cred2_r), .sat(sat2_r),
    .one_minus_sat(oms2_r), .val(val3_r), .result(out_red)
  );

  h2r_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_green (
    .clk(clk), .adv(adv), .chan(cgrn2_r), .sat(sat2_r),
    .one_minus_sat(oms2_r), .val(val3_r), .result(out_green)
  );

  h2r_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_blue (
    .clk(clk), .adv(adv), .chan(cblu2_r), .sat(sat2_r),
    .one_minus_sat(oms2_r), .val(val3_r), .result(out_blue)
  );

  // Back-pressure only reaches the input once every stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (vld1_r && vld2_r && vld3_r && vld4_r))
    else $error("input stalled with a free pipeline stage");

  // Every sector has one channel at full scale
  a_full_chan: assert property (@(posedge clk) disable iff (!rst_n)
    vld2_r |-> (cred2_r == ONE || cgrn2_r == ONE || cblu2_r == ONE))
    else $error("no full-scale channel in sector stage");

  // Blend results never exceed 1.0
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red <= ONE && out_green <= ONE && out_blue <= ONE))
    else $error("colour channel above full scale");

endmodule

`default_nettype wire

// ===== hw/rtl/h2r_blend.sv =====
// ----------------------------------------------------------------------------
// h2r_blend
// Two-stage blend of one channel: ((s*c >> F) + (1 - s)) * v >> F.
// ----------------------------------------------------------------------------
`default_nettype none

module h2r_blend #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic                 clk,
  input  wire h2r_pkg::h2r_adv_t    adv,
  input  wire logic [FRAC_BITS:0]   chan,
  input  wire logic [FRAC_BITS:0]   sat,
  input  wire logic [FRAC_BITS:0]   one_minus_sat,
  input  wire logic [FRAC_BITS:0]   val,
  output logic      [FRAC_BITS:0]   result
);
  import h2r_pkg::*;

  localparam int W = FRAC_BITS + 1;

  logic [2*W-1:0] sc_prod;
  logic [W-1:0]   mix_nxt;
  logic [W-1:0]   mix_r;
  logic [2*W-1:0] mv_prod;
  logic [W-1:0]   out_nxt;
  logic [W-1:0]   out_r;

  // s*c <= s, so the sum never exceeds 1.0
  always_comb begin
    sc_prod = sat * chan;
    mix_nxt = sc_prod[FRAC_BITS +: W] + one_minus_sat;
  end

  always_comb begin
    mv_prod = mix_r * val;
    out_nxt = mv_prod[FRAC_BITS +: W];
  end

  always_ff @(posedge clk) begin
    if (adv.mix_en) begin
      mix_r <= mix_nxt;
    end
    if (adv.out_en) begin
      out_r <= out_nxt;
    end
  end

  assign result = out_r;

endmodule

`default_nettype wire
